FILE: rtl/cft_pkg.sv
// shared types and constants of the tcp connection tracking firewall
`default_nettype none
package cft_pkg;

	localparam int RANK_W = 4;

	localparam logic [31:0] NETWORK_RST = 32'h0a00_0000;
	localparam logic [31:0] NETMASK_RST = 32'hff00_0000;

	localparam logic [63:0] HASH_K1 = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] HASH_C2 = 64'h632B_E59B_D9B4_E019;
	localparam logic [63:0] HASH_K2 = 64'hC2B2_AE3D_27D4_EB4F;

	localparam logic CFG_NETWORK = 1'b0;
	localparam logic CFG_NETMASK = 1'b1;

	localparam int FLAG_SYN = 0;
	localparam int FLAG_ACK = 1;
	localparam int FLAG_FIN = 2;
	localparam int FLAG_RST = 3;

	localparam logic [2:0] L4_OTHER0 = 3'd0;
	localparam logic [2:0] L4_OTHER2 = 3'd2;

	localparam logic [1:0] REQ_NONE = 2'd0;
	localparam logic [1:0] REQ_PASS = 2'd1;
	localparam logic [1:0] REQ_DROP = 2'd2;

	localparam logic [1:0] PH_SYN_SENT = 2'd1;
	localparam logic [1:0] PH_ESTABLISHED = 2'd2;
	localparam logic [1:0] PH_FIN = 2'd3;

	typedef struct packed {
		logic [31:0] la;
		logic [31:0] ha;
		logic [15:0] lp;
		logic [15:0] hp;
		logic [7:0]  proto;
	} key_t;

	typedef struct packed {
		logic              valid;
		logic [63:0]       addrs;
		logic [39:0]       pp;
		logic [1:0]        phase;
		logic              offload;
		logic [63:0]       seen;
		logic [RANK_W-1:0] rank;
	} entry_t;

	typedef struct packed {
		logic       drop;
		logic [1:0] req;
	} decision_t;

	typedef struct packed {
		logic       rd_en;
		logic       dec_en;
		logic       outbound;
		logic [3:0] flags;
	} table_ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_MUL,
		ST_MIX,
		ST_READ,
		ST_DEC
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/tcp_conntrack_firewall.sv
// top level: input filter, canonical key, sequencer and result registers
// results: a tracked packet's result is registered after the hash pipe, the set read
//   and the update; a packet that passes untouched has it registered on the accepting edge
// intake: busy stays high while a tracked packet is in the hash pipe, set read, update
//   and write back of the set row; one untouched packet per cycle while busy is low
// reset: every set row of the memory is swept after reset with busy high; results are
//   strobed for one cycle and cannot stall
`default_nettype none
module tcp_conntrack_firewall import cft_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int TABLE_WAYS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] source_address,
	input  wire logic [31:0] destination_address,
	input  wire logic [15:0] source_port,
	input  wire logic [15:0] destination_port,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic [2:0]  nic_l4_kind,
	input  wire logic [3:0]  tcp_flag_bits,
	input  wire logic        headers_present,
	input  wire logic        nic_pass_tag,
	input  wire logic [63:0] arrival_time,
	output logic             done,
	output logic             verdict,
	output logic [1:0]       rule_request,
	output logic [31:0]      rule_low_address,
	output logic [31:0]      rule_high_address,
	output logic [15:0]      rule_low_port,
	output logic [15:0]      rule_high_port,
	output logic [7:0]       rule_protocol
);

	localparam int SET_COUNT = TABLE_ENTRIES / TABLE_WAYS;
	localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;

	state_t state_q, state_d;
	logic [31:0] network_q, netmask_q;
	key_t key_q, key_d;
	logic [3:0] flags_q;
	logic [63:0] now_q;
	logic outbound_q;
	logic accept, bypass, swap;
	logic [SET_W-1:0] set_idx;
	logic clear_busy;
	table_ctl_t ctl;
	decision_t decision;

	logic done_q, verdict_q;
	logic [1:0] req_q;
	key_t rule_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			network_q <= NETWORK_RST;
			netmask_q <= NETMASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NETWORK: network_q <= cfg_data;
				CFG_NETMASK: netmask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		accept = start && !busy;
		bypass = nic_pass_tag || !headers_present ||
		         nic_l4_kind == L4_OTHER0 || nic_l4_kind == L4_OTHER2;
		swap = {source_address, source_port} > {destination_address, destination_port};
		key_d.la    = swap ? destination_address : source_address;
		key_d.lp    = swap ? destination_port : source_port;
		key_d.ha    = swap ? source_address : destination_address;
		key_d.hp    = swap ? source_port : destination_port;
		key_d.proto = ip_protocol;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q      <= key_d;
			flags_q    <= tcp_flag_bits;
			now_q      <= arrival_time;
			outbound_q <= (source_address & netmask_q) == network_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		ctl.rd_en = 1'b0;
		ctl.dec_en = 1'b0;
		ctl.outbound = outbound_q;
		ctl.flags = flags_q;
		case (state_q)
			ST_CLEAR: begin
				if (!clear_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (accept && !bypass) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_MIX;
			ST_MIX:  state_d = ST_READ;
			ST_READ: begin
				ctl.rd_en = 1'b1;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				ctl.dec_en = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	cft_hash #(
		.SET_COUNT(SET_COUNT),
		.SET_W(SET_W)
	) u_hash (
		.clk(clk),
		.key(key_q),
		.set_idx(set_idx)
	);

	cft_table #(
		.SET_COUNT(SET_COUNT),
		.SET_W(SET_W),
		.WAYS(TABLE_WAYS)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.rd_set(set_idx),
		.key(key_q),
		.now(now_q),
		.clear_busy(clear_busy),
		.decision(decision)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && bypass) || ctl.dec_en;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && bypass) begin
			verdict_q <= 1'b0;
			req_q     <= REQ_NONE;
			rule_q    <= '0;
		end else if (ctl.dec_en) begin
			verdict_q <= decision.drop;
			req_q     <= decision.req;
			rule_q    <= (decision.req != REQ_NONE) ? key_q : '0;
		end
	end

	assign done              = done_q;
	assign verdict           = verdict_q;
	assign rule_request      = req_q;
	assign rule_low_address  = rule_q.la;
	assign rule_high_address = rule_q.ha;
	assign rule_low_port     = rule_q.lp;
	assign rule_high_port    = rule_q.hp;
	assign rule_protocol     = rule_q.proto;

endmodule
`default_nettype wire

FILE: rtl/cft_hash.sv
// three stage multiplicative hash of the canonical key down to a set index
`default_nettype none
module cft_hash import cft_pkg::*; #(
	parameter int SET_COUNT = 256,
	parameter int SET_W = 8
) (
	input  wire logic             clk,
	input  wire key_t             key,
	output logic      [SET_W-1:0] set_idx
);

	logic [63:0] a_s1, q_s1;
	logic [63:0] p1ll_s2, p2ll_s2;
	logic [31:0] p1lh_s2, p1hl_s2, p2lh_s2, p2hl_s2;
	logic [63:0] h1, h2, h, hm;
	logic [SET_W-1:0] set_s3;

	always_ff @(posedge clk) begin
		a_s1 <= {key.la, key.ha};
		q_s1 <= {24'd0, key.lp, key.hp, key.proto} + HASH_C2;
	end

	// low 64 bits of each product from 32x32 partial products
	always_ff @(posedge clk) begin
		p1ll_s2 <= a_s1[31:0] * HASH_K1[31:0];
		p1lh_s2 <= 32'(a_s1[31:0] * HASH_K1[63:32]);
		p1hl_s2 <= 32'(a_s1[63:32] * HASH_K1[31:0]);
		p2ll_s2 <= q_s1[31:0] * HASH_K2[31:0];
		p2lh_s2 <= 32'(q_s1[31:0] * HASH_K2[63:32]);
		p2hl_s2 <= 32'(q_s1[63:32] * HASH_K2[31:0]);
	end

	always_comb begin
		h1 = p1ll_s2 + {p1lh_s2 + p1hl_s2, 32'd0};
		h2 = p2ll_s2 + {p2lh_s2 + p2hl_s2, 32'd0};
		h  = h1 ^ h2;
		hm = h ^ (h >> 29);
	end

	always_ff @(posedge clk) begin
		set_s3 <= hm[SET_W-1:0] & SET_W'(SET_COUNT - 1);
	end

	assign set_idx = set_s3;

endmodule
`default_nettype wire

FILE: rtl/cft_table.sv
// conntrack memory: clearing pass, set read, lookup, lru update and write back
`default_nettype none
module cft_table import cft_pkg::*; #(
	parameter int SET_COUNT = 256,
	parameter int SET_W = 8,
	parameter int WAYS = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire table_ctl_t       ctl,
	input  wire logic [SET_W-1:0] rd_set,
	input  wire key_t             key,
	input  wire logic [63:0]      now,
	output logic                  clear_busy,
	output decision_t             decision
);

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	entry_t [WAYS-1:0] table_mem [SET_COUNT];
	entry_t [WAYS-1:0] rd_row_s1;
	entry_t [WAYS-1:0] upd_row, wr_row;
	logic   [SET_W-1:0] set_q, clr_idx_q, wr_addr;
	logic               clr_busy_q, wr_en;

	logic [63:0] key_addrs;
	logic [39:0] key_pp;
	logic [WAY_W-1:0] hit_way, inv_way, lru_way, tgt;
	logic hit_any, inv_any, insert;
	logic syn, ack, fin, rst;
	logic [RANK_W-1:0] tgt_rank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == SET_W'(SET_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_row_s1 <= table_mem[rd_set];
			set_q     <= rd_set;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_row;
		end
	end

	always_comb begin
		key_addrs = {key.la, key.ha};
		key_pp    = {key.lp, key.hp, key.proto};
		syn = ctl.flags[FLAG_SYN];
		ack = ctl.flags[FLAG_ACK];
		fin = ctl.flags[FLAG_FIN];
		rst = ctl.flags[FLAG_RST];

		hit_any = 1'b0;
		inv_any = 1'b0;
		hit_way = '0;
		inv_way = '0;
		lru_way = '0;
		// walk down so the lowest way wins
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_row_s1[w].valid && rd_row_s1[w].addrs == key_addrs &&
			    rd_row_s1[w].pp == key_pp) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!rd_row_s1[w].valid) begin
				inv_any = 1'b1;
				inv_way = WAY_W'(w);
			end
			// ranks form a permutation, the oldest way holds the top rank
			if (rd_row_s1[w].rank == RANK_W'(WAYS - 1)) begin
				lru_way = WAY_W'(w);
			end
		end

		insert = !hit_any && syn && !ack && ctl.outbound;
		tgt = hit_any ? hit_way : (inv_any ? inv_way : lru_way);
		tgt_rank = rd_row_s1[tgt].rank;

		upd_row = rd_row_s1;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == tgt) begin
				upd_row[w].rank = '0;
			end else if (rd_row_s1[w].rank < tgt_rank) begin
				upd_row[w].rank = rd_row_s1[w].rank + 1'b1;
			end
		end

		decision.drop = 1'b0;
		decision.req  = REQ_NONE;
		if (hit_any) begin
			if (rst) begin
				// pass, entry kept as is apart from recency
			end else if (fin) begin
				upd_row[tgt].phase = PH_FIN;
				upd_row[tgt].seen  = now;
			end else if (rd_row_s1[tgt].phase == PH_SYN_SENT && syn && ack &&
			             !ctl.outbound) begin
				upd_row[tgt].phase   = PH_ESTABLISHED;
				upd_row[tgt].offload = 1'b1;
				upd_row[tgt].seen    = now;
				decision.req         = REQ_PASS;
			end else begin
				upd_row[tgt].seen = now;
			end
		end else if (insert) begin
			upd_row[tgt].valid   = 1'b1;
			upd_row[tgt].addrs   = key_addrs;
			upd_row[tgt].pp      = key_pp;
			upd_row[tgt].phase   = PH_SYN_SENT;
			upd_row[tgt].offload = 1'b0;
			upd_row[tgt].seen    = now;
		end else begin
			decision.drop = 1'b1;
			decision.req  = REQ_DROP;
		end

		if (clr_busy_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			for (int w = 0; w < WAYS; w++) begin
				wr_row[w]      = '0;
				wr_row[w].rank = RANK_W'(w);
			end
		end else begin
			wr_en   = ctl.dec_en && (hit_any || insert);
			wr_addr = set_q;
			wr_row  = upd_row;
		end
	end

	assign clear_busy = clr_busy_q;

endmodule
`default_nettype wire

FILE: rtl/cft_checker.sv
// port level checks of the firewall results, bound to the top level
`default_nettype none
module cft_checker import cft_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        verdict,
	input wire logic [1:0]  rule_request,
	input wire logic [31:0] rule_low_address,
	input wire logic [31:0] rule_high_address,
	input wire logic [15:0] rule_low_port,
	input wire logic [15:0] rule_high_port,
	input wire logic [7:0]  rule_protocol
);

	// every result follows an accepted item or a running one
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without an item");

	a_drop_rule: assert property (@(posedge clk) disable iff (!arst_n)
		done && verdict |-> rule_request == REQ_DROP)
		else $error("drop without drop rule");

	a_req_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rule_request == REQ_NONE || rule_request == REQ_PASS ||
		          rule_request == REQ_DROP))
		else $error("bad rule code");

	a_no_rule_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rule_request == REQ_NONE |->
		(rule_low_address == 32'd0 && rule_high_address == 32'd0 &&
		 rule_low_port == 16'd0 && rule_high_port == 16'd0 && rule_protocol == 8'd0))
		else $error("rule key not cleared");

	a_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		done && rule_request != REQ_NONE |->
		{rule_low_address, rule_low_port} <= {rule_high_address, rule_high_port})
		else $error("rule key not canonical");

endmodule

bind tcp_conntrack_firewall cft_checker u_cft_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.verdict(verdict),
	.rule_request(rule_request),
	.rule_low_address(rule_low_address),
	.rule_high_address(rule_high_address),
	.rule_low_port(rule_low_port),
	.rule_high_port(rule_high_port),
	.rule_protocol(rule_protocol)
);
`default_nettype wire
